// ===== design/assert_macros.svh =====
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define I2P_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define I2P_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/i2p_pkg.sv =====
package i2p_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW   = 2'd1;
    localparam logic [1:0] ERR_UNM_CLOSE  = 2'd2;
    localparam logic [1:0] ERR_UNM_OPEN   = 2'd3;

    typedef enum logic [2:0] {
        OP_OPEN = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_code_t;

    typedef enum logic [2:0] {
        CLS_ALNUM,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OPER,
        CLS_OTHER
    } char_class_t;

    typedef enum logic [1:0] {
        EMIT_IN,
        EMIT_TOP,
        EMIT_ERR
    } emit_sel_t;

    typedef struct packed {
        logic        load;
        logic        emit;
        emit_sel_t   emit_sel;
        logic [1:0]  err;
        logic        push;
        logic        pop;
        logic        finish;
    } ctl_cmd_t;

    typedef struct packed {
        char_class_t cls;
        logic        end_flag;
        logic        count_zero;
        logic        count_full;
        logic        top_is_open;
        logic        top_rank_ge;
        logic        can_emit;
        logic        out_free;
    } ctl_sts_t;

    function automatic char_class_t char_class(input logic [7:0] c);
        char_class_t cls;
        unique case (c) inside
            [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]: cls = CLS_ALNUM;
            CHAR_OPEN:                                   cls = CLS_OPEN;
            CHAR_CLOSE:                                  cls = CLS_CLOSE;
            CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH: cls = CLS_OPER;
            default:                                     cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

    // Stack code for a byte; '(' and every non-operator map to the open code.
    function automatic op_code_t op_code_of(input logic [7:0] c);
        op_code_t code;
        unique case (c)
            CHAR_PLUS:  code = OP_ADD;
            CHAR_MINUS: code = OP_SUB;
            CHAR_STAR:  code = OP_MUL;
            CHAR_SLASH: code = OP_DIV;
            default:    code = OP_OPEN;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] code_char(input op_code_t code);
        logic [7:0] c;
        unique case (code)
            OP_OPEN: c = CHAR_OPEN;
            OP_ADD:  c = CHAR_PLUS;
            OP_SUB:  c = CHAR_MINUS;
            OP_MUL:  c = CHAR_STAR;
            OP_DIV:  c = CHAR_SLASH;
            default: c = CHAR_OPEN;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] code_rank(input op_code_t code);
        logic [1:0] r;
        unique case (code)
            OP_ADD, OP_SUB: r = 2'd1;
            OP_MUL, OP_DIV: r = 2'd2;
            default:        r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/i2p_in_if.sv =====
interface i2p_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_expr;

    modport source (output valid, output in_char, output end_of_expr, input ready);
    modport sink (input valid, input in_char, input end_of_expr, output ready);
endinterface

// ===== design/i2p_out_if.sv =====
interface i2p_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       last;
    logic [1:0] error_code;

    modport source (output valid, output out_char, output char_valid, output last,
                    output error_code, input ready);
    modport sink (input valid, input out_char, input char_valid, input last,
                  input error_code, output ready);
endinterface

// ===== design/i2p_ram.sv =====
module i2p_ram #(
    parameter int WIDTH  = 3,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/i2p_ctrl.sv =====
module i2p_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  i2p_pkg::ctl_sts_t  sts,
    output i2p_pkg::ctl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CLOSE,
        ST_OPPOP,
        ST_FLUSH,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t after_item;

    assign after_item = sts.end_flag ? ST_FLUSH : ST_DONE;
    assign in_ready   = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.emit_sel = i2p_pkg::EMIT_IN;
        cmd.err      = i2p_pkg::ERR_NONE;
        state_next   = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (sts.cls)
                    i2p_pkg::CLS_ALNUM:
                    begin
                        if (sts.can_emit)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = after_item;
                        end
                    end
                    i2p_pkg::CLS_OPEN:
                    begin
                        if (!sts.count_full)
                        begin
                            cmd.push   = 1'b1;
                            state_next = after_item;
                        end
                        else if (sts.can_emit)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = i2p_pkg::EMIT_ERR;
                            cmd.err      = i2p_pkg::ERR_OVERFLOW;
                            state_next   = after_item;
                        end
                    end
                    i2p_pkg::CLS_CLOSE: state_next = ST_CLOSE;
                    i2p_pkg::CLS_OPER:  state_next = ST_OPPOP;
                    default:            state_next = after_item;
                endcase
            end
            ST_CLOSE:
            begin
                if (sts.count_zero)
                begin
                    if (sts.can_emit)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = i2p_pkg::EMIT_ERR;
                        cmd.err      = i2p_pkg::ERR_UNM_CLOSE;
                        state_next   = after_item;
                    end
                end
                else if (sts.top_is_open)
                begin
                    cmd.pop    = 1'b1;
                    state_next = after_item;
                end
                else if (sts.can_emit)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = i2p_pkg::EMIT_TOP;
                    cmd.pop      = 1'b1;
                end
            end
            ST_OPPOP:
            begin
                if (!sts.count_zero && sts.top_rank_ge)
                begin
                    if (sts.can_emit)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = i2p_pkg::EMIT_TOP;
                        cmd.pop      = 1'b1;
                    end
                end
                else if (!sts.count_full)
                begin
                    cmd.push   = 1'b1;
                    state_next = after_item;
                end
                else if (sts.can_emit)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = i2p_pkg::EMIT_ERR;
                    cmd.err      = i2p_pkg::ERR_OVERFLOW;
                    state_next   = after_item;
                end
            end
            ST_FLUSH:
            begin
                if (sts.count_zero)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.can_emit)
                begin
                    cmd.emit = 1'b1;
                    cmd.pop  = 1'b1;
                    if (sts.top_is_open)
                    begin
                        cmd.emit_sel = i2p_pkg::EMIT_ERR;
                        cmd.err      = i2p_pkg::ERR_UNM_OPEN;
                    end
                    else
                    begin
                        cmd.emit_sel = i2p_pkg::EMIT_TOP;
                    end
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/i2p_datapath.sv =====
module i2p_datapath #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         in_char,
    input  logic               end_of_expr,
    input  i2p_pkg::ctl_cmd_t  cmd,
    output i2p_pkg::ctl_sts_t  sts,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_char,
    output logic               char_valid,
    output logic               last,
    output logic [1:0]         error_code
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [7:0]        char_reg;
    logic              end_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    i2p_pkg::op_code_t top_reg;
    logic              use_ram_reg;
    logic [2:0]        ram_q;
    i2p_pkg::op_code_t top_code;
    i2p_pkg::op_code_t push_code;
    logic [CW-1:0]     raddr_full;

    // One result is held back so that the final one of an item can carry last.
    logic              hold_valid_reg;
    logic [7:0]        hold_char_reg;
    logic              hold_cv_reg;
    logic [1:0]        hold_err_reg;
    logic [7:0]        new_char;
    logic              new_cv;
    logic [1:0]        new_err;

    logic              out_valid_reg;
    logic [7:0]        out_char_reg;
    logic              out_cv_reg;
    logic              out_last_reg;
    logic [1:0]        out_err_reg;
    logic              out_free;
    logic              out_load;

    assign push_code = i2p_pkg::op_code_of(char_reg);
    assign top_code  = use_ram_reg ? i2p_pkg::op_code_t'(ram_q) : top_reg;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // The memory always reads the entry that will be on top next cycle; a push
    // bypasses it through top_reg.
    assign raddr_full = count_next - CW'(1);

    i2p_ram #(
        .WIDTH (3),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (count_reg[AW-1:0]),
        .wdata (push_code),
        .raddr (raddr_full[AW-1:0]),
        .rdata (ram_q)
    );

    assign out_free = !out_valid_reg || out_ready;

    assign sts.cls         = i2p_pkg::char_class(char_reg);
    assign sts.end_flag    = end_reg;
    assign sts.count_zero  = (count_reg == '0);
    assign sts.count_full  = (count_reg == CW'(STACK_DEPTH));
    assign sts.top_is_open = (top_code == i2p_pkg::OP_OPEN);
    assign sts.top_rank_ge = (i2p_pkg::code_rank(top_code) >= i2p_pkg::code_rank(push_code));
    assign sts.can_emit    = !hold_valid_reg || out_free;
    assign sts.out_free    = out_free;

    always_comb
    begin
        case (cmd.emit_sel)
            i2p_pkg::EMIT_IN:
            begin
                new_char = char_reg;
                new_cv   = 1'b1;
                new_err  = i2p_pkg::ERR_NONE;
            end
            i2p_pkg::EMIT_TOP:
            begin
                new_char = i2p_pkg::code_char(top_code);
                new_cv   = 1'b1;
                new_err  = i2p_pkg::ERR_NONE;
            end
            default:
            begin
                new_char = 8'h00;
                new_cv   = 1'b0;
                new_err  = cmd.err;
            end
        endcase
    end

    assign out_load = (cmd.emit && hold_valid_reg) ||
                      (cmd.finish && (hold_valid_reg || end_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            use_ram_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.push)
            begin
                use_ram_reg <= 1'b0;
            end
            else if (cmd.pop)
            begin
                use_ram_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg <= in_char;
            end_reg  <= end_of_expr;
        end
        if (cmd.push)
        begin
            top_reg <= push_code;
        end
        if (cmd.emit)
        begin
            hold_char_reg <= new_char;
            hold_cv_reg   <= new_cv;
            hold_err_reg  <= new_err;
        end
        if (out_load)
        begin
            if (hold_valid_reg)
            begin
                out_char_reg <= hold_char_reg;
                out_cv_reg   <= hold_cv_reg;
                out_err_reg  <= hold_err_reg;
                out_last_reg <= cmd.finish && end_reg;
            end
            else
            begin
                out_char_reg <= 8'h00;
                out_cv_reg   <= 1'b0;
                out_err_reg  <= i2p_pkg::ERR_NONE;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign char_valid = out_cv_reg;
    assign last       = out_last_reg;
    assign error_code = out_err_reg;

endmodule

// ===== design/infix_to_postfix_converter_unit.sv =====
// Shunting-yard infix to postfix converter. One byte of infix text is taken per
// transaction on in_ch and the postfix characters come out one per transaction on
// out_ch; faults come out as their own transactions with char_valid low and an
// error code, and the final transaction of an expression (end_of_expr set) carries
// last, a bare end marker being sent when nothing else would be. Items are handled
// one at a time: an item passes from acceptance to the next ready through load,
// decode and hand-off steps, with a further step for a ')', an operator or an end
// of expression, and a step of its own per operator it pops to the output and per
// entry it flushes; the '(' that closes a ')' search is dropped without a step of
// its own, and any stall on the output side lengthens it. The operator stack sits
// in a single-port-write RAM of STACK_DEPTH entries and pops one entry per cycle
// while the output can take results. One result is held internally until the next
// is known, so each item's results are complete only at its hand-off cycle.
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    i2p_in_if.sink    in_ch,
    i2p_out_if.source out_ch
);

    i2p_pkg::ctl_cmd_t cmd;
    i2p_pkg::ctl_sts_t sts;
    logic              in_ready;
    logic              out_valid;
    logic [7:0]        out_char;
    logic              char_valid;
    logic              last;
    logic [1:0]        error_code;

    i2p_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    i2p_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_char     (in_ch.in_char),
        .end_of_expr (in_ch.end_of_expr),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ch.ready),
        .out_char    (out_char),
        .char_valid  (char_valid),
        .last        (last),
        .error_code  (error_code)
    );

    assign in_ch.ready       = in_ready;
    assign out_ch.valid      = out_valid;
    assign out_ch.out_char   = out_char;
    assign out_ch.char_valid = char_valid;
    assign out_ch.last       = last;
    assign out_ch.error_code = error_code;

endmodule

// ===== design/i2p_checker.sv =====
`include "assert_macros.svh"

module i2p_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       char_valid,
    input logic       last,
    input logic [1:0] error_code
);

    `I2P_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output dropped while stalled")
    `I2P_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_char) && $stable(char_valid) && $stable(last) && $stable(error_code), "output changed while stalled")
    `I2P_ASSERT_IMPL(a_err_no_char, out_valid && error_code != i2p_pkg::ERR_NONE, !char_valid && out_char == 8'h00, "error transaction carries a character")
    `I2P_ASSERT_IMPL(a_bare_is_last, out_valid && !char_valid && error_code == i2p_pkg::ERR_NONE, last && out_char == 8'h00, "empty transaction is not an end marker")

endmodule

bind infix_to_postfix_converter_unit i2p_checker u_i2p_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_char   (out_ch.out_char),
    .char_valid (out_ch.char_valid),
    .last       (out_ch.last),
    .error_code (out_ch.error_code)
);

// ===== tb/infix_to_postfix_converter_unit_tb.sv =====
module infix_to_postfix_converter_unit_tb;

    localparam int STACK_DEPTH  = i2p_pkg::STACK_DEPTH_DEF;
    localparam int ITEM_TARGET  = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 30;

    typedef struct packed {
        logic [7:0] ch;
        logic       char_valid;
        logic       last;
        logic [1:0] err;
    } postfix_result_t;

    logic clk;
    logic rst_n;

    i2p_in_if  in_ch ();
    i2p_out_if out_ch ();

    infix_to_postfix_converter_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    postfix_result_t expected_postfix[$];
    logic [7:0]      pending_ops[$];

    bit idle_off      = 1'b0;
    int hold_request  = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int scored_items    = 0;
    int ignored_items   = 0;
    int overflow_count  = 0;
    int unmatched_count = 0;
    int deepest_stack   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_operand(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic int op_rank(input logic [7:0] op);
        if (op == i2p_pkg::CHAR_STAR || op == i2p_pkg::CHAR_SLASH)
            return 2;
        if (op == i2p_pkg::CHAR_PLUS || op == i2p_pkg::CHAR_MINUS)
            return 1;
        return 0;
    endfunction

    function automatic postfix_result_t char_result(input logic [7:0] ch);
        postfix_result_t r;
        r.ch         = ch;
        r.char_valid = 1'b1;
        r.last       = 1'b0;
        r.err        = i2p_pkg::ERR_NONE;
        return r;
    endfunction

    // Faults and the bare end marker carry no character.
    function automatic postfix_result_t marker_result(input logic [1:0] err);
        postfix_result_t r;
        r.ch         = 8'h00;
        r.char_valid = 1'b0;
        r.last       = 1'b0;
        r.err        = err;
        return r;
    endfunction

    function automatic void shunting_yard_step(input logic [7:0] c, input logic eoe);
        postfix_result_t step_q[$];
        postfix_result_t tail;
        logic [7:0]      top;
        bit              found;
        found = 1'b0;
        if (is_operand(c))
        begin
            step_q.push_back(char_result(c));
        end
        else if (c == i2p_pkg::CHAR_CLOSE)
        begin
            while (pending_ops.size() > 0 && !found)
            begin
                top = pending_ops.pop_back();
                if (top == i2p_pkg::CHAR_OPEN)
                    found = 1'b1;
                else
                    step_q.push_back(char_result(top));
            end
            if (!found)
            begin
                step_q.push_back(marker_result(i2p_pkg::ERR_UNM_CLOSE));
                unmatched_count++;
            end
        end
        else if (c == i2p_pkg::CHAR_OPEN || op_rank(c) > 0)
        begin
            // An operator first drains everything of equal or higher rank; an open
            // parenthesis ranks lowest, so it is never drained here.
            if (c != i2p_pkg::CHAR_OPEN)
            begin
                while (pending_ops.size() > 0 && op_rank(pending_ops[$]) >= op_rank(c))
                    step_q.push_back(char_result(pending_ops.pop_back()));
            end
            if (pending_ops.size() < STACK_DEPTH)
            begin
                pending_ops.push_back(c);
                if (pending_ops.size() > deepest_stack)
                    deepest_stack = pending_ops.size();
            end
            else
            begin
                step_q.push_back(marker_result(i2p_pkg::ERR_OVERFLOW));
                overflow_count++;
            end
        end
        if (eoe)
        begin
            while (pending_ops.size() > 0)
            begin
                top = pending_ops.pop_back();
                if (top == i2p_pkg::CHAR_OPEN)
                begin
                    step_q.push_back(marker_result(i2p_pkg::ERR_UNM_OPEN));
                    unmatched_count++;
                end
                else
                begin
                    step_q.push_back(char_result(top));
                end
            end
            if (step_q.size() == 0)
                step_q.push_back(marker_result(i2p_pkg::ERR_NONE));
            tail = step_q.pop_back();
            tail.last = 1'b1;
            step_q.push_back(tail);
        end
        foreach (step_q[i])
            expected_postfix.push_back(step_q[i]);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic send_infix_byte(input logic [7:0] c, input logic eoe);
        if (!idle_off && $urandom_range(99) < 25)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 25)
                @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_char     <= c;
        in_ch.end_of_expr <= eoe;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        shunting_yard_step(c, eoe);
        if (is_operand(c) || c == i2p_pkg::CHAR_OPEN || c == i2p_pkg::CHAR_CLOSE ||
            op_rank(c) > 0 || eoe)
            scored_items++;
        else
            ignored_items++;
    endtask

    // Valid is lowered ahead of the next burst so that it never gets
    // two updates in one step.
    task automatic end_burst();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_text(input string txt, input bit eoe_on_last);
        for (int i = 0; i < txt.len(); i++)
            send_infix_byte(txt[i], eoe_on_last && (i == txt.len() - 1));
    endtask

    task automatic send_sequence(input logic [7:0] seq[$]);
        for (int i = 0; i < seq.size(); i++)
            send_infix_byte(seq[i], i == seq.size() - 1);
    endtask

    function automatic logic [7:0] random_operand();
        case ($urandom_range(2))
            0:       return "0" + 8'($urandom_range(9));
            1:       return "A" + 8'($urandom_range(25));
            default: return "a" + 8'($urandom_range(25));
        endcase
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(3))
            0:       return i2p_pkg::CHAR_PLUS;
            1:       return i2p_pkg::CHAR_MINUS;
            2:       return i2p_pkg::CHAR_STAR;
            default: return i2p_pkg::CHAR_SLASH;
        endcase
    endfunction

    task automatic send_expression(input bit broken);
        logic [7:0] expr_q[$];
        int         terms;
        int         depth;
        int         pos;
        terms = $urandom_range(1, 6);
        depth = 0;
        for (int t = 0; t < terms; t++)
        begin
            if (t > 0)
                expr_q.push_back(random_operator());
            while (depth < 5 && $urandom_range(3) == 0)
            begin
                expr_q.push_back(i2p_pkg::CHAR_OPEN);
                depth++;
            end
            if ($urandom_range(9) == 0)
                expr_q.push_back(" ");
            expr_q.push_back(random_operand());
            while (depth > 0 && $urandom_range(2) == 0)
            begin
                expr_q.push_back(i2p_pkg::CHAR_CLOSE);
                depth--;
            end
        end
        if (!broken)
        begin
            while (depth > 0)
            begin
                expr_q.push_back(i2p_pkg::CHAR_CLOSE);
                depth--;
            end
        end
        else
        begin
            pos = $urandom_range(expr_q.size() - 1);
            case ($urandom_range(2))
                0:
                begin
                    if (expr_q.size() > 1)
                        expr_q.delete(pos);
                end
                1:       expr_q.insert(pos, i2p_pkg::CHAR_CLOSE);
                default: expr_q.insert(pos, 8'($urandom_range(255)));
            endcase
        end
        send_sequence(expr_q);
    endtask

    task automatic send_deep_nesting();
        logic [7:0] seq[$];
        int         opens;
        opens = $urandom_range(10, STACK_DEPTH + 4);
        repeat (opens)
            seq.push_back(i2p_pkg::CHAR_OPEN);
        seq.push_back(random_operand());
        seq.push_back(random_operator());
        seq.push_back(random_operand());
        repeat ($urandom_range(opens))
            seq.push_back(i2p_pkg::CHAR_CLOSE);
        send_sequence(seq);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
            send_infix_byte(8'($urandom_range(255)), $urandom_range(5) == 0);
    endtask

    task automatic test_operands_and_ignored_bytes();
        // Range edges of the operand classes, neighbors that are ignored, and an
        // end marker on an ignored byte with an empty stack.
        send_text("09AZaz", 1'b0);
        send_infix_byte(8'h00, 1'b0);
        send_infix_byte(8'hFF, 1'b0);
        send_infix_byte("@", 1'b1);
        send_infix_byte("{", 1'b1);
        end_burst();
    endtask

    task automatic test_operator_precedence();
        send_text("a+b*c-d/e", 1'b1);
        send_text("x/y*z", 1'b1);
        end_burst();
    endtask

    task automatic test_parentheses_and_faults();
        // The second close has no open left: the pending operator is emitted and
        // then the fault. The trailing open is still pending at the flush.
        send_text("a*(b-c))", 1'b0);
        send_text("(d", 1'b1);
        end_burst();
    endtask

    task automatic test_stack_overflow();
        repeat (STACK_DEPTH + 1)
            send_infix_byte(i2p_pkg::CHAR_OPEN, 1'b0);
        send_infix_byte(i2p_pkg::CHAR_STAR, 1'b0);
        send_infix_byte("x", 1'b1);
        end_burst();
    endtask

    task automatic test_output_backpressure();
        idle_off = 1'b1;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 48; i++)
            send_infix_byte((i % 8 == 7) ? random_operator() : random_operand(), i == 47);
        end_burst();
        idle_off = 1'b0;
    endtask

    task automatic test_back_to_back_stream();
        idle_off = 1'b1;
        repeat (5)
            send_expression(1'b0);
        end_burst();
        idle_off = 1'b0;
    endtask

    task automatic test_random_expressions();
        int start_count;
        int pick;
        start_count = scored_items;
        while (scored_items - start_count < ITEM_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_expression(pick < 10);
            else if (pick < 82)
                send_deep_nesting();
            else
                send_noise();
        end
        end_burst();
    endtask

    // Output side: random stalls, plus a long hold-off on request.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ch.ready <= idle_off || ($urandom_range(99) >= 25);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        postfix_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_checked++;
            if (expected_postfix.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transaction: char %02h valid %0b last %0b err %0d",
                                          out_ch.out_char, out_ch.char_valid, out_ch.last,
                                          out_ch.error_code));
            end
            else
            begin
                want = expected_postfix.pop_front();
                if (out_ch.out_char !== want.ch || out_ch.char_valid !== want.char_valid ||
                    out_ch.last !== want.last || out_ch.error_code !== want.err)
                    report_mismatch($sformatf(
                        "got char %02h valid %0b last %0b err %0d, want %02h %0b %0b %0d",
                        out_ch.out_char, out_ch.char_valid, out_ch.last, out_ch.error_code,
                        want.ch, want.char_valid, want.last, want.err));
            end
        end
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, expected_postfix.size());
        $display("infix_to_postfix_converter_unit_tb: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.in_char     = 8'h00;
        in_ch.end_of_expr = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_operands_and_ignored_bytes();
        test_operator_precedence();
        test_parentheses_and_faults();
        test_stack_overflow();
        test_output_backpressure();
        test_back_to_back_stream();
        test_random_expressions();

        while (expected_postfix.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d scored and %0d ignored bytes; checked %0d postfix results.",
                 scored_items, ignored_items, results_checked);
        $display("Stack reached depth %0d; %0d overflow and %0d unmatched parenthesis faults.",
                 deepest_stack, overflow_count, unmatched_count);
        if (mismatch_count == 0 && expected_postfix.size() == 0)
            $display("infix_to_postfix_converter_unit_tb: PASS");
        else
            $display("infix_to_postfix_converter_unit_tb: FAIL");
        $finish;
    end

endmodule
